/* hdl/ipv4_icmp_packet_validator_macros.svh */
// ----------------------------------------------------------------------------
// IPv4/ICMP validator assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef IPV4_ICMP_PACKET_VALIDATOR_MACROS_SVH
`define IPV4_ICMP_PACKET_VALIDATOR_MACROS_SVH

// same-cycle implication
`define IPV4ICMP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipv4icmp: implication check failed");

// next-cycle implication
`define IPV4ICMP_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipv4icmp: next-cycle check failed");

`endif

/* hdl/ipv4icmp_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4/ICMP validator package
// Constants, status codes, shared structs and the ones'-complement adder.
// ----------------------------------------------------------------------------
package ipv4icmp_pkg;

   localparam int MAX_PACKET_BYTES = 2048;
   localparam int COUNT_W          = $clog2(MAX_PACKET_BYTES + 1);
   localparam int IPV4_MIN_HDR     = 20;
   localparam int ICMP_MIN_HDR     = 8;
   localparam int IP_CHECK_AT      = 10;
   localparam int PROTO_AT         = 9;
   localparam logic [7:0] PROTO_ICMP = 8'd1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNDER20   = 3'd1,
      ST_IHL_SMALL = 3'd2,
      ST_NOT_ICMP  = 3'd3,
      ST_SHORT     = 3'd4,
      ST_IP_CSUM   = 3'd5,
      ST_ICMP_CSUM = 3'd6,
      ST_TOO_LONG  = 3'd7
   } status_type;

   // packet state as it stands after the byte in hand
   typedef struct packed {
      logic               overflow;
      logic [COUNT_W-1:0] len;
      logic [3:0]         ihl;
      logic [7:0]         proto;
      logic [15:0]        ip_sum;
      logic [15:0]        icmp_sum;
      logic [15:0]        ip_chk;
      logic [15:0]        icmp_chk;
      logic [15:0]        type_code;
   } pkt_state_type;

   // result word, lowest field last
   typedef struct packed {
      logic [1:0]  pad;
      logic [7:0]  icmp_code;
      logic [7:0]  icmp_type;
      logic [11:0] icmp_bytes;
      logic [5:0]  header_bytes;
      status_type  status;
      logic        accept;
   } result_type;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

/* hdl/ipv4icmp_in_reg.sv */
// ----------------------------------------------------------------------------
// IPv4/ICMP validator input register
// Holds one byte transfer until the tracking logic consumes it.
// ----------------------------------------------------------------------------
module ipv4icmp_in_reg import ipv4icmp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       take,
   output logic       in_valid,
   output logic [7:0] in_byte,
   output logic       in_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;
   assign in_last  = last_ff;

endmodule

/* hdl/ipv4icmp_accum.sv */
// ----------------------------------------------------------------------------
// IPv4/ICMP validator packet tracker
// Byte count, header captures and the two running checksums.
// ----------------------------------------------------------------------------
module ipv4icmp_accum import ipv4icmp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   output pkt_state_type nxt
);

   pkt_state_type      cur_ff, cur_in;
   logic [7:0]         pend_ff, pend_in;

   always_comb begin
      logic [COUNT_W-1:0] off;
      logic [COUNT_W-1:0] hb;
      logic [COUNT_W-1:0] start;
      logic [15:0]        word;
      logic               full;
      off   = cur_ff.len;
      hb    = COUNT_W'({cur_ff.ihl, 2'b00});
      start = {off[COUNT_W-1:1], 1'b0};
      // odd offset closes a word; an even last byte is padded with zero
      word  = off[0] ? {pend_ff, in_byte} : {in_byte, 8'h00};
      full  = (cur_ff.len == COUNT_W'(MAX_PACKET_BYTES));
      nxt     = cur_ff;
      pend_in = pend_ff;
      if (full) begin
         nxt.overflow = 1'b1;
      end else begin
         nxt.len = cur_ff.len + COUNT_W'(1);
         if (off == '0) begin
            nxt.ihl = in_byte[3:0];
         end
         if (off == COUNT_W'(PROTO_AT)) begin
            nxt.proto = in_byte;
         end
         if (off == hb) begin
            nxt.type_code[15:8] = in_byte;
         end
         if (off == hb + COUNT_W'(1)) begin
            nxt.type_code[7:0] = in_byte;
         end
         if (!off[0]) begin
            pend_in = in_byte;
         end
         if (off[0] || in_last) begin
            if (start < hb) begin
               if (off[0] && start == COUNT_W'(IP_CHECK_AT)) begin
                  nxt.ip_chk = word;
               end else begin
                  nxt.ip_sum = oc_add(cur_ff.ip_sum, word);
               end
            end else begin
               if (off[0] && start == hb + COUNT_W'(2)) begin
                  nxt.icmp_chk = word;
               end else begin
                  nxt.icmp_sum = oc_add(cur_ff.icmp_sum, word);
               end
            end
         end
      end
   end

   // the last byte clears everything for the next packet
   always_comb begin
      cur_in = nxt;
      if (in_last) begin
         cur_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         pend_ff <= '0;
      end else if (step) begin
         cur_ff  <= cur_in;
         pend_ff <= in_last ? 8'h00 : pend_in;
      end
   end

endmodule

/* hdl/ipv4icmp_verdict.sv */
// ----------------------------------------------------------------------------
// IPv4/ICMP validator verdict
// Turns the final packet state into status, accept, length, ICMP type and code fields.
// ----------------------------------------------------------------------------
module ipv4icmp_verdict import ipv4icmp_pkg::*; (
   input  pkt_state_type st,
   output result_type    res
);

   logic [COUNT_W-1:0] hb;
   logic               ip_bad;
   logic               icmp_bad;
   status_type         status;

   assign hb       = COUNT_W'({st.ihl, 2'b00});
   assign ip_bad   = st.ip_chk != ~st.ip_sum;
   assign icmp_bad = st.icmp_chk != ~st.icmp_sum;

   always_comb begin
      if (st.overflow) begin
         status = ST_TOO_LONG;
      end else if (st.len < COUNT_W'(IPV4_MIN_HDR)) begin
         status = ST_UNDER20;
      end else if (st.ihl < 4'd5) begin
         status = ST_IHL_SMALL;
      end else if (st.proto != PROTO_ICMP) begin
         status = ST_NOT_ICMP;
      end else if (st.len < hb + COUNT_W'(ICMP_MIN_HDR)) begin
         status = ST_SHORT;
      end else if (ip_bad) begin
         status = ST_IP_CSUM;
      end else if (icmp_bad) begin
         status = ST_ICMP_CSUM;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      res              = '0;
      res.accept       = (status == ST_OK);
      res.status       = status;
      res.header_bytes = {st.ihl, 2'b00};
      res.icmp_bytes   = (st.len > hb) ? 12'(st.len - hb) : 12'd0;
      res.icmp_type    = st.type_code[15:8];
      res.icmp_code    = st.type_code[7:0];
   end

endmodule

/* hdl/ipv4icmp_out_reg.sv */
// ----------------------------------------------------------------------------
// IPv4/ICMP validator result register
// Holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module ipv4icmp_out_reg import ipv4icmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  res_in,
   output logic        out_free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff;

endmodule

/* hdl/ipv4_icmp_packet_validator.sv */
// A packet's result is registered in the result register when its last byte leaves the input register.
// Throughput: one byte per cycle while the result register has room for each last byte.
// A last byte waits in the input register only while the result register is still full.
// Reset clears both handshake registers and all packet state.
// ----------------------------------------------------------------------------
// IPv4/ICMP packet validator
// Checks an IPv4 packet streamed a byte at a time and reports an ICMP verdict.
// ----------------------------------------------------------------------------
module ipv4_icmp_packet_validator import ipv4icmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // accept, status[2:0], header_bytes[5:0],
                                    // icmp_bytes[11:0], icmp_type[7:0],
                                    // icmp_code[7:0], zero pad
);

   logic          in_valid;
   logic [7:0]    in_byte;
   logic          in_last;
   logic          take;
   logic          out_free;
   pkt_state_type nxt;
   result_type    res;

   // a last byte moves only when there is room for its result
   assign take = in_valid && (!in_last || out_free);

   ipv4icmp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .in_valid   (in_valid),
      .in_byte    (in_byte),
      .in_last    (in_last)
   );

   ipv4icmp_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .step    (take),
      .in_byte (in_byte),
      .in_last (in_last),
      .nxt     (nxt)
   );

   ipv4icmp_verdict u_verdict (
      .st  (nxt),
      .res (res)
   );

   ipv4icmp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (take && in_last),
      .res_in     (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hdl/ipv4icmp_checker.sv */
// ----------------------------------------------------------------------------
// IPv4/ICMP validator port checker
// Watches the top-level ports for result consistency and stall behavior.
// ----------------------------------------------------------------------------
`include "ipv4_icmp_packet_validator_macros.svh"

module ipv4icmp_checker import ipv4icmp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   logic unused_in;
   assign unused_in = req_tvalid ^ req_tready ^ req_tlast ^ (^req_tdata);

   // a stalled result holds
   `IPV4ICMP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // accept agrees with the status code
   `IPV4ICMP_ASSERT_IMP(a_accept_status, clock, reset, rsp_tvalid, rsp_tdata[0] == (rsp_tdata[3:1] == ST_OK))

   // header length is a whole number of words
   `IPV4ICMP_ASSERT_IMP(a_hdr_words, clock, reset, rsp_tvalid, rsp_tdata[5:4] == 2'b00)

   // an accepted packet has at least a minimal header
   `IPV4ICMP_ASSERT_IMP(a_accept_hdr, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[9:4] >= 6'(IPV4_MIN_HDR))

   // reset empties the result register
   `IPV4ICMP_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind ipv4_icmp_packet_validator ipv4icmp_checker u_checker (.*);
